>>> rtl/ddsdac_pkg.sv
// Package for the DDS sine sigma-delta DAC: types, register codes, reset values
// and the half-period sine level table.
// Depends on nothing; every other file of the block but ddsdac_ram uses it.
package ddsdac_pkg;

	// Fixed field widths.
	localparam int LEVEL_W        = 8;
	localparam int STEP_W         = 16;
	localparam int HOLD_W         = 10;
	localparam int FS_W           = 8;
	localparam int INTEG_W        = 10;
	localparam int TABLE_DEPTH    = 256;
	localparam int TABLE_IDX_W    = $clog2(TABLE_DEPTH);
	localparam int PHASE_BITS_DEF = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHIRP_ENABLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 2'd3;

	// Reset values.
	localparam logic [STEP_W-1:0]  STEP_RESET       = STEP_W'(200 * 49);
	localparam logic [HOLD_W-1:0]  HOLD_RESET       = HOLD_W'(200);
	localparam logic [FS_W-1:0]    FULL_SCALE_RESET = FS_W'(255);
	localparam logic [LEVEL_W-1:0] MID_LEVEL        = LEVEL_W'(128);

	// The phase RAM holds a single live entry at address zero.
	localparam int PHASE_RAM_DEPTH = 2;
	localparam int PHASE_RAM_AW    = $clog2(PHASE_RAM_DEPTH);

	// Magnitudes of the first half of the sine period; the second half is negated.
	localparam logic [6:0] SINE_HALF [TABLE_DEPTH/2] = '{
		7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd15,  7'd18,  7'd21,
		7'd24,  7'd27,  7'd30,  7'd33,  7'd36,  7'd39,  7'd42,  7'd45,
		7'd48,  7'd51,  7'd54,  7'd57,  7'd59,  7'd62,  7'd65,  7'd67,
		7'd70,  7'd73,  7'd75,  7'd78,  7'd80,  7'd82,  7'd85,  7'd87,
		7'd89,  7'd91,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd103,
		7'd105, 7'd107, 7'd108, 7'd110, 7'd112, 7'd113, 7'd114, 7'd116,
		7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd123,
		7'd124, 7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd126, 7'd126,
		7'd127, 7'd126, 7'd126, 7'd126, 7'd126, 7'd126, 7'd125, 7'd125,
		7'd124, 7'd123, 7'd123, 7'd122, 7'd121, 7'd120, 7'd119, 7'd118,
		7'd117, 7'd116, 7'd114, 7'd113, 7'd112, 7'd110, 7'd108, 7'd107,
		7'd105, 7'd103, 7'd102, 7'd100, 7'd98,  7'd96,  7'd94,  7'd91,
		7'd89,  7'd87,  7'd85,  7'd82,  7'd80,  7'd78,  7'd75,  7'd73,
		7'd70,  7'd67,  7'd65,  7'd62,  7'd59,  7'd57,  7'd54,  7'd51,
		7'd48,  7'd45,  7'd42,  7'd39,  7'd36,  7'd33,  7'd30,  7'd27,
		7'd24,  7'd21,  7'd18,  7'd15,  7'd12,  7'd9,   7'd6,   7'd3
	};

	// Target level for a table index: mid level plus the signed sine value.
	function automatic logic [LEVEL_W-1:0] sine_level(input logic [TABLE_IDX_W-1:0] idx);
		logic [LEVEL_W-1:0] mag;
		mag = {1'b0, SINE_HALF[idx[TABLE_IDX_W-2:0]]};
		return idx[TABLE_IDX_W-1] ? (MID_LEVEL - mag) : (MID_LEVEL + mag);
	endfunction

	// One configuration write.
	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// What the DDS stage hands to the modulator for one tick.
	typedef struct packed {
		logic               new_sample;
		logic [LEVEL_W-1:0] target;
	} dds_out_t;

	// One result word.
	typedef struct packed {
		logic               dac_bit;
		logic               new_sample;
		logic [LEVEL_W-1:0] target_level;
	} result_t;

endpackage

>>> rtl/ddsdac_if.sv
// Handshake channels of the DDS sine sigma-delta DAC: tick words in, result words out.
// Depends on ddsdac_pkg for the level width.
interface ddsdac_tick_if;
	logic valid;
	logic ready;
	logic run;

	modport source (output valid, output run, input ready);
	modport sink (input valid, input run, output ready);
endinterface

interface ddsdac_result_if;
	logic                              valid;
	logic                              ready;
	logic                              dac_bit;
	logic                              new_sample;
	logic [ddsdac_pkg::LEVEL_W-1:0]    target_level;

	modport source (output valid, output dac_bit, output new_sample, output target_level,
		input ready);
	modport sink (input valid, input dac_bit, input new_sample, input target_level,
		output ready);
endinterface

>>> rtl/ddsdac_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module ddsdac_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; returns the contents before a write at the same edge.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/ddsdac_dds.sv
// DDS front end: phase accumulator kept in a RAM with write-back forwarding,
// step and hold counters, and the sine level lookup. Depends on ddsdac_pkg, ddsdac_ram.
module ddsdac_dds #(
	parameter int PHASE_BITS = ddsdac_pkg::PHASE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ddsdac_pkg::cfg_wr_t  cfg,
	input  logic                 tick_go,
	output ddsdac_pkg::dds_out_t dds
);

	localparam int AW = ddsdac_pkg::PHASE_RAM_AW;

	logic [ddsdac_pkg::HOLD_W-1:0]  hold_ticks_q;
	logic                           chirp_q;
	logic [ddsdac_pkg::STEP_W-1:0]  current_step_q;
	logic [ddsdac_pkg::HOLD_W-1:0]  hold_count_q;
	logic [ddsdac_pkg::LEVEL_W-1:0] target_q;
	logic                           phase_valid_q;
	logic                           fwd_hit_q;
	logic [PHASE_BITS-1:0]          fwd_q;

	logic [PHASE_BITS-1:0]          phase_rd;
	logic [PHASE_BITS-1:0]          phase_cur;
	logic [PHASE_BITS-1:0]          phase_next;
	logic                           fetch;
	logic [ddsdac_pkg::LEVEL_W-1:0] level;

	// Phase store: one entry, read every cycle, written back on each fetch.
	ddsdac_ram #(
		.WIDTH (PHASE_BITS),
		.DEPTH (ddsdac_pkg::PHASE_RAM_DEPTH)
	) u_phase_ram (
		.clk   (clk),
		.we    (fetch),
		.waddr (AW'(0)),
		.wdata (phase_next),
		.re    (1'b1),
		.raddr (AW'(0)),
		.rdata (phase_rd)
	);

	// The registered RAM read does not yet show the word just written, so the last written word is forwarded.
	// Before the first write the entry reads as zero.
	assign phase_cur  = fwd_hit_q ? fwd_q : (phase_valid_q ? phase_rd : '0);
	assign phase_next = phase_cur + PHASE_BITS'(current_step_q);
	assign fetch      = tick_go && (hold_count_q == '0);
	assign level      = ddsdac_pkg::sine_level(
		phase_cur[PHASE_BITS-1 -: ddsdac_pkg::TABLE_IDX_W]);

	assign dds.new_sample = fetch;
	assign dds.target     = fetch ? level : target_q;

	// Forwarding register and valid mark for the phase entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q     <= 1'b0;
			phase_valid_q <= 1'b0;
		end else begin
			fwd_hit_q <= fetch;
			if (fetch) begin
				phase_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fetch) begin
			fwd_q <= phase_next;
		end
	end

	// Configuration registers, step, hold count and held target.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q   <= ddsdac_pkg::HOLD_RESET;
			chirp_q        <= 1'b0;
			current_step_q <= ddsdac_pkg::STEP_RESET;
			hold_count_q   <= '0;
			target_q       <= ddsdac_pkg::MID_LEVEL;
		end else begin
			if (cfg.we) begin
				case (cfg.index)
					ddsdac_pkg::REG_PHASE_STEP: begin
						current_step_q <= cfg.data[ddsdac_pkg::STEP_W-1:0];
					end
					ddsdac_pkg::REG_HOLD_TICKS: begin
						hold_ticks_q <= cfg.data[ddsdac_pkg::HOLD_W-1:0];
					end
					ddsdac_pkg::REG_CHIRP_ENABLE: begin
						chirp_q <= cfg.data[0];
					end
					default: begin
					end
				endcase
			end
			if (fetch) begin
				target_q     <= level;
				hold_count_q <= (hold_ticks_q == '0) ? '0 : hold_ticks_q - 1'b1;
				if (chirp_q) begin
					current_step_q <= current_step_q + 1'b1;
				end
			end else if (tick_go) begin
				hold_count_q <= hold_count_q - 1'b1;
			end
		end
	end

	// A fetch always leaves the forwarding path armed for the next cycle.
	a_fetch_forwards: assert property (@(posedge clk) disable iff (!arst_n)
		fetch |=> fwd_hit_q && phase_valid_q)
		else $error("phase write-back not forwarded");

	// A running tick between fetches counts the hold down by one.
	a_hold_counts: assert property (@(posedge clk) disable iff (!arst_n)
		tick_go && (hold_count_q != '0) |=> hold_count_q == $past(hold_count_q) - 1'b1)
		else $error("hold count did not step");

	// The step changes only at a fetch or a step register write.
	a_step_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!fetch && !(cfg.we && cfg.index == ddsdac_pkg::REG_PHASE_STEP)
		|=> $stable(current_step_q))
		else $error("phase step changed without a fetch");

endmodule

>>> rtl/ddsdac_mod.sv
// First-order sigma-delta modulator: saturating integrator and one-bit feedback.
// Depends on ddsdac_pkg.
module ddsdac_mod (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ddsdac_pkg::cfg_wr_t  cfg,
	input  logic                 tick_go,
	input  ddsdac_pkg::dds_out_t dds,
	output logic                 dac_bit
);

	localparam int SUM_W = ddsdac_pkg::INTEG_W + 1;
	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (ddsdac_pkg::INTEG_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(1 << (ddsdac_pkg::INTEG_W - 1));

	logic signed [ddsdac_pkg::INTEG_W-1:0] integ_q;
	logic                                  fb_q;
	logic [ddsdac_pkg::FS_W-1:0]           full_scale_q;
	logic signed [SUM_W-1:0]               sum;
	logic signed [SUM_W-1:0]               sum_sat;
	logic [ddsdac_pkg::FS_W-1:0]           fb_val;

	// Integrator update: add the target, subtract the feedback, clamp to range.
	always_comb begin
		fb_val = fb_q ? full_scale_q : '0;
		sum    = SUM_W'(integ_q)
			+ $signed(SUM_W'(dds.target))
			- $signed(SUM_W'(fb_val));
		if (sum > SAT_MAX) begin
			sum_sat = SAT_MAX;
		end else if (sum < SAT_MIN) begin
			sum_sat = SAT_MIN;
		end else begin
			sum_sat = sum;
		end
	end

	assign dac_bit = tick_go ? (sum_sat > 0) : fb_q;

	// Loop state and the full-scale register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q      <= '0;
			fb_q         <= 1'b0;
			full_scale_q <= ddsdac_pkg::FULL_SCALE_RESET;
		end else begin
			if (cfg.we && cfg.index == ddsdac_pkg::REG_FULL_SCALE) begin
				full_scale_q <= cfg.data[ddsdac_pkg::FS_W-1:0];
			end
			if (tick_go) begin
				integ_q <= sum_sat[ddsdac_pkg::INTEG_W-1:0];
				fb_q    <= (sum_sat > 0);
			end
		end
	end

endmodule

>>> rtl/ddsdac_outbuf.sv
// Two-entry output buffer (output register plus skid word) for result words.
// Depends on ddsdac_pkg.
module ddsdac_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ddsdac_pkg::result_t din,
	output logic                can_push,
	output logic                out_valid,
	input  logic                out_ready,
	output ddsdac_pkg::result_t dout
);

	logic                ov_q;
	logic                sv_q;
	ddsdac_pkg::result_t o_q;
	ddsdac_pkg::result_t s_q;
	logic                head_free;

	assign head_free = !ov_q || out_ready;
	assign can_push  = !sv_q;
	assign out_valid = ov_q;
	assign dout      = o_q;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (head_free) begin
			ov_q <= sv_q || push;
			sv_q <= 1'b0;
		end else if (push) begin
			sv_q <= 1'b1;
		end
	end

	// Data words: the head refills from the skid word first.
	always_ff @(posedge clk) begin
		if (head_free) begin
			if (sv_q) begin
				o_q <= s_q;
			end else if (push) begin
				o_q <= din;
			end
		end else if (push) begin
			s_q <= din;
		end
	end

	// The skid word is only ever occupied behind a waiting head word.
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |-> ov_q)
		else $error("skid word held without a head word");

	// A waiting head word that is not taken stays in place.
	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ready |=> ov_q && $stable(o_q))
		else $error("head word lost while stalled");

	// Nothing is pushed into a full buffer.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !sv_q)
		else $error("push into full output buffer");

endmodule

>>> rtl/dds_sine_sigma_delta_dac_unit.sv
// Sine-driven first-order sigma-delta DAC: each tick word yields one result word
// with the modulator bit, the new-sample mark and the target level in use. The block
// takes one tick per clock cycle, back to back; each result is registered, and a
// stalled output is absorbed by a one-word skid stage, so input stalls only after
// two results wait. The phase accumulator lives in a one-entry RAM with registered
// read; the word written at a fetch is forwarded to the next cycle, which sets the
// critical path: forwarding select, sine table lookup, then the integrator add and
// clamp. No clearing pass is needed after reset. The user must write configuration
// through cfg_we, cfg_index and cfg_data only while idle; the block does not check.
// Depends on ddsdac_pkg, ddsdac_if, ddsdac_dds, ddsdac_mod and ddsdac_outbuf.
module dds_sine_sigma_delta_dac_unit #(
	parameter int PHASE_BITS = ddsdac_pkg::PHASE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ddsdac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ddsdac_pkg::CFG_DATA_W-1:0] cfg_data,
	ddsdac_tick_if.sink                       tick,
	ddsdac_result_if.source                   result
);

	ddsdac_pkg::cfg_wr_t  cfg;
	ddsdac_pkg::dds_out_t dds;
	ddsdac_pkg::result_t  res_in;
	ddsdac_pkg::result_t  res_out;
	logic                 accept;
	logic                 tick_go;
	logic                 dac_bit;
	logic                 can_push;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// A tick word is taken whenever the output buffer has room.
	assign tick.ready = can_push;
	assign accept     = tick.valid && can_push;
	assign tick_go    = accept && tick.run;

	// Phase, step and target level.
	ddsdac_dds #(
		.PHASE_BITS (PHASE_BITS)
	) u_dds (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.tick_go (tick_go),
		.dds     (dds)
	);

	// Sigma-delta loop.
	ddsdac_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.tick_go (tick_go),
		.dds     (dds),
		.dac_bit (dac_bit)
	);

	// Result word for this tick.
	assign res_in.dac_bit      = dac_bit;
	assign res_in.new_sample   = dds.new_sample;
	assign res_in.target_level = dds.target;

	ddsdac_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.din       (res_in),
		.can_push  (can_push),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.dout      (res_out)
	);

	assign result.dac_bit      = res_out.dac_bit;
	assign result.new_sample   = res_out.new_sample;
	assign result.target_level = res_out.target_level;

endmodule
